@@ hdl/bpcwf_pkg.sv @@
package bpcwf_pkg;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_SVPWM_MODE        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_BIAS      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTLIER_THRESHOLD = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CURRENT_LIMIT     = 2'd3;

    localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RESET = 12'd50;
    localparam logic [CFG_DATA_BITS-1:0] LIMIT_RESET     = 12'd2000;

    // Input side-band: hall_code [2:0], reverse_dir [3], run_flag [4]
    localparam int HALL_BITS     = 3;
    localparam int IN_TUSER_BITS = 5;

    localparam logic [HALL_BITS-1:0] HALL_ALL_LOW  = 3'd0;
    localparam logic [HALL_BITS-1:0] HALL_ALL_HIGH = 3'd7;

    // Phase codes; also the window and sample slot of that phase
    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_V = 2'd1;
    localparam logic [1:0] PH_W = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_TEST = 7'b0000010,
        ST_ACC  = 7'b0000100,
        ST_NORM = 7'b0001000,
        ST_MUL  = 7'b0010000,
        ST_MEAN = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    // Conducting phase for a valid hall code and rotation direction
    function automatic logic [1:0] phase_select(input logic [HALL_BITS-1:0] hall,
                                                input logic rev);
        logic [1:0] ph;
        ph = PH_U;
        if (!rev)
        begin
            unique case (hall)
                3'd1:    ph = PH_W;
                3'd2:    ph = PH_V;
                3'd3:    ph = PH_W;
                3'd6:    ph = PH_V;
                default: ph = PH_U;
            endcase
        end
        else
        begin
            unique case (hall)
                3'd1:    ph = PH_V;
                3'd4:    ph = PH_W;
                3'd5:    ph = PH_V;
                3'd6:    ph = PH_W;
                default: ph = PH_U;
            endcase
        end
        return ph;
    endfunction

endpackage

@@ hdl/bldc_phase_current_window_filter.sv @@
// An invalid hall code in six-step mode holds the output. A new set is taken only in idle,
// after the last result is loaded. Each phase (one six-step, three SVPWM) runs 5 steps,
// test, accumulate, normalize, multiply, mean: a window memory read-modify-write and one
// reciprocal multiply. Reset (rst_n low, asynchronous) clears sums, means, fill count,
// write slot, control and config registers; datapath and window memory stay undefined.
module bldc_phase_current_window_filter #(
    parameter int WINDOW_DEPTH = 8,
    parameter int SAMPLE_BITS  = 12,
    localparam int IN_TDATA_W  = ((3 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((4 * (SAMPLE_BITS + 1) + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bpcwf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [bpcwf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [IN_TDATA_W-1:0]                s_axis_tdata,  // adc_u, adc_v, adc_w, zero fill
    input  logic [bpcwf_pkg::IN_TUSER_BITS-1:0]  s_axis_tuser,  // hall_code, reverse_dir, run_flag
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [OUT_TDATA_W-1:0]               m_axis_tdata   // phase_current, current_u,
                                                                // current_v, current_w, zero fill
);
    import bpcwf_pkg::*;

    // Internal sample width covers a bias of up to CFG_DATA_BITS bits
    localparam int XB = (SAMPLE_BITS > CFG_DATA_BITS) ? SAMPLE_BITS : CFG_DATA_BITS;
    localparam int XW = XB + 1;
    localparam int L  = $clog2(WINDOW_DEPTH);
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int NW = XB + L;
    localparam int SW = NW + 1;
    localparam int K  = NW + L;
    localparam int RW = K + 1;
    localparam int PW = NW + RW;
    localparam int CW = XW + 2;
    localparam int AW = 2 + L;
    localparam int OW = SAMPLE_BITS + 1;

    // Reciprocal table: ceil(2^K / d) for divisors d = 1 .. WINDOW_DEPTH
    logic [RW-1:0] recip_tab [WINDOW_DEPTH];

    for (genvar gi = 0; gi < WINDOW_DEPTH; gi++)
    begin : g_recip
        localparam longint unsigned RECIP_VAL = ((64'd1 << K) + gi) / (gi + 1);
        assign recip_tab[gi] = RW'(RECIP_VAL);
    end

    // Control and configuration state
    state_t                     state_reg, state_next;
    logic [1:0]                 phase_reg, phase_next;
    logic [FW-1:0]              fill_reg, fill_next;
    logic [L-1:0]               slot_reg, slot_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       svpwm_reg;
    logic [CFG_DATA_BITS-1:0]   bias_reg;
    logic [CFG_DATA_BITS-1:0]   thr_reg;
    logic [CFG_DATA_BITS-1:0]   limit_reg;
    logic signed [SW-1:0]       sums_reg  [3];
    logic signed [XW-1:0]       means_reg [4];

    // Datapath registers
    logic signed [XW-1:0]       x_reg [3];
    logic                       run_reg;
    logic signed [XW-1:0]       xsel_reg;
    logic signed [XW-1:0]       rdata_reg;
    logic signed [SW-1:0]       acc_sum_reg;
    logic                       neg_reg;
    logic [NW-1:0]              num_reg;
    logic [L-1:0]               idx_reg;
    logic [PW-1:0]              prod_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;

    // Window memory: entry {window, slot}
    logic signed [XW-1:0]       store_mem [4 << L];

    logic                       in_xfer;
    logic                       out_load;
    logic                       full;
    logic                       hall_ok;
    logic [1:0]                 mean_idx;
    logic [AW-1:0]              mem_addr;
    logic [HALL_BITS-1:0]       hall;
    logic [SAMPLE_BITS-1:0]     raw_u, raw_v, raw_w, raw_six;
    logic signed [XW-1:0]       prep_u, prep_v, prep_w, prep_six;
    logic signed [XW-1:0]       x_cur, mean_cur;
    logic signed [CW-1:0]       dev, thr_s;
    logic                       outlier;
    logic signed [XW-1:0]       old_val;
    logic signed [SW-1:0]       sum_new, sum_mag;
    logic [NW-1:0]              num_next;
    logic [XB-1:0]              quot;
    logic signed [XW-1:0]       q_ext, mean_val, limit_s, mean_fin;
    logic [OUT_TDATA_W-1:0]     out_data_next;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);
    assign full     = (fill_reg == FW'(WINDOW_DEPTH));
    assign mean_idx = svpwm_reg ? (phase_reg + 2'd1) : 2'd0;
    assign mem_addr = {phase_reg, slot_reg};

    // Unpack input and subtract bias; raw never exceeds the sample maximum
    // after bias removal, so the upper clamp reduces to nothing
    always_comb
    begin
        raw_u   = s_axis_tdata[0 +: SAMPLE_BITS];
        raw_v   = s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS];
        raw_w   = s_axis_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS];
        hall    = s_axis_tuser[HALL_BITS-1:0];
        hall_ok = (hall != HALL_ALL_LOW) && (hall != HALL_ALL_HIGH);
        unique case (phase_select(hall, s_axis_tuser[HALL_BITS]))
            PH_V:    raw_six = raw_v;
            PH_W:    raw_six = raw_w;
            default: raw_six = raw_u;
        endcase
        prep_u   = XW'(raw_u) - XW'(bias_reg);
        prep_v   = XW'(raw_v) - XW'(bias_reg);
        prep_w   = XW'(raw_w) - XW'(bias_reg);
        prep_six = XW'(raw_six) - XW'(bias_reg);
    end

    // Outlier test against the window's own mean (full window only)
    always_comb
    begin
        x_cur    = x_reg[phase_reg];
        mean_cur = means_reg[mean_idx];
        dev      = CW'(x_cur) - CW'(mean_cur);
        thr_s    = CW'(thr_reg);
        outlier  = full && ((dev > thr_s) || (dev < -thr_s));
    end

    // Sum update: drop the overwritten entry once the window is full
    always_comb
    begin
        old_val = full ? rdata_reg : '0;
        sum_new = sums_reg[phase_reg] + SW'(xsel_reg) - SW'(old_val);
    end

    // Divide magnitude: floor for a full window, truncation while filling
    always_comb
    begin
        sum_mag  = acc_sum_reg[SW-1] ? -acc_sum_reg : acc_sum_reg;
        num_next = sum_mag[NW-1:0]
                 + ((full && acc_sum_reg[SW-1]) ? NW'(WINDOW_DEPTH - 1) : '0);
    end

    // Rebuild signed mean and apply the run-mode limit in six-step mode
    always_comb
    begin
        quot     = prod_reg[K +: XB];
        q_ext    = XW'(quot);
        mean_val = neg_reg ? -q_ext : q_ext;
        limit_s  = XW'(limit_reg);
        mean_fin = mean_val;
        if (!svpwm_reg && run_reg && (mean_val > limit_s))
        begin
            mean_fin = limit_s;
        end
    end

    // Pack the result fields
    always_comb
    begin
        out_data_next = '0;
        if (svpwm_reg)
        begin
            out_data_next[OW +: OW]     = means_reg[1][OW-1:0];
            out_data_next[2 * OW +: OW] = means_reg[2][OW-1:0];
            out_data_next[3 * OW +: OW] = means_reg[3][OW-1:0];
        end
        else
        begin
            out_data_next[0 +: OW] = means_reg[0][OW-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        fill_next    = fill_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    phase_next = PH_U;
                    if (!svpwm_reg && !hall_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_TEST;
                    end
                end
            end
            ST_TEST: state_next = ST_ACC;
            ST_ACC:  state_next = ST_NORM;
            ST_NORM: state_next = ST_MUL;
            ST_MUL:  state_next = ST_MEAN;
            ST_MEAN:
            begin
                if (svpwm_reg && (phase_reg != PH_W))
                begin
                    phase_next = phase_reg + 2'd1;
                    state_next = ST_TEST;
                end
                else
                begin
                    if (!full)
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    slot_next  = (slot_reg == L'(WINDOW_DEPTH - 1)) ? '0 : slot_reg + L'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_U;
            fill_reg    <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
            svpwm_reg   <= 1'b0;
            bias_reg    <= '0;
            thr_reg     <= THRESHOLD_RESET;
            limit_reg   <= LIMIT_RESET;
            for (int i = 0; i < 3; i++)
            begin
                sums_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                means_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            fill_reg    <= fill_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;

            // Take register writes on every configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_SVPWM_MODE:        svpwm_reg <= cfg_data[0];
                    CFG_CURRENT_BIAS:      bias_reg  <= cfg_data;
                    CFG_OUTLIER_THRESHOLD: thr_reg   <= cfg_data;
                    CFG_CURRENT_LIMIT:     limit_reg <= cfg_data;
                    default:               ;
                endcase
            end

            if (state_reg == ST_ACC)
            begin
                sums_reg[phase_reg] <= sum_new;
            end

            if (state_reg == ST_MEAN)
            begin
                means_reg[mean_idx] <= mean_fin;
            end
        end
    end

    // Datapath pipeline registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            x_reg[0] <= svpwm_reg ? prep_u : prep_six;
            x_reg[1] <= prep_v;
            x_reg[2] <= prep_w;
            run_reg  <= s_axis_tuser[HALL_BITS + 1];
        end
        if (state_reg == ST_TEST)
        begin
            xsel_reg <= outlier ? mean_cur : x_cur;
        end
        if (state_reg == ST_ACC)
        begin
            acc_sum_reg <= sum_new;
        end
        if (state_reg == ST_NORM)
        begin
            neg_reg <= acc_sum_reg[SW-1];
            num_reg <= num_next;
            idx_reg <= full ? L'(WINDOW_DEPTH - 1) : fill_reg[L-1:0];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PW'(num_reg) * PW'(recip_tab[idx_reg]);
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Window memory: read the leaving entry, write back the new one
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_TEST)
        begin
            rdata_reg <= store_mem[mem_addr];
        end
        if (state_reg == ST_ACC)
        begin
            store_mem[mem_addr] <= xsel_reg;
        end
    end

endmodule

@@ sim/tb_bldc_phase_current_window_filter.sv @@
module tb_bldc_phase_current_window_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import bpcwf_pkg::*;

    localparam int SAMPLE_BITS  = 12;
    localparam int CURRENT_BITS = SAMPLE_BITS + 1;
    localparam int WINDOW       = 8;
    localparam int WINDOW_SHIFT = 3;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int IN_W         = ((3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W        = ((4 * CURRENT_BITS + 7) / 8) * 8;
    localparam int MAX_REPORTS  = 10;
    localparam int LONG_STALL   = 400;
    localparam int SEGMENTS     = 9;
    localparam int SEGMENT_SETS = 117;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    // One raw sample set as it travels on the input stream
    typedef struct packed {
        logic                   run;
        logic                   rev;
        logic [HALL_BITS-1:0]   hall;
        logic [SAMPLE_BITS-1:0] w;
        logic [SAMPLE_BITS-1:0] v;
        logic [SAMPLE_BITS-1:0] u;
    } sample_set_t;

    // phase_current, current_u, current_v, current_w from index 0 up
    typedef logic [3:0][CURRENT_BITS-1:0] current_set_t;

    // Tracks filter state and holds the currents still owed by the block
    class window_current_board;
        int           svpwm;
        int           bias;
        int           threshold;
        int           limit;
        int           window_data [3][WINDOW];
        int           window_sum [3];
        int           fill;
        int           slot;
        int           mean [4];
        current_set_t expected_currents [$];
        int           fail_count;

        function new();
            svpwm      = 0;
            bias       = 0;
            threshold  = THRESHOLD_RESET;
            limit      = LIMIT_RESET;
            fill       = 0;
            slot       = 0;
            fail_count = 0;
            foreach (window_data[w, s])
                window_data[w][s] = 0;
            foreach (window_sum[w])
                window_sum[w] = 0;
            foreach (mean[m])
                mean[m] = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_SVPWM_MODE:        svpwm = val[0];
                CFG_CURRENT_BIAS:      bias = val;
                CFG_OUTLIER_THRESHOLD: threshold = val;
                CFG_CURRENT_LIMIT:     limit = val;
                default: ;
            endcase
        endfunction

        function int remove_bias(logic [SAMPLE_BITS-1:0] raw);
            int x;
            x = raw;
            x = x - bias;
            if (x > SAMPLE_MAX)
                x = SAMPLE_MAX;
            return x;
        endfunction

        // Push one sample into window w and refresh mean m
        function void filter_into(int w, int m, int x);
            int dev;
            if (fill < WINDOW)
            begin
                window_data[w][slot] = x;
                window_sum[w] += x;
                mean[m] = window_sum[w] / (fill + 1);
            end
            else
            begin
                dev = x - mean[m];
                if (dev > threshold || dev < -threshold)
                    x = mean[m];
                window_sum[w] += x - window_data[w][slot];
                window_data[w][slot] = x;
                mean[m] = window_sum[w] >>> WINDOW_SHIFT;
            end
        endfunction

        function void advance_slot();
            if (fill < WINDOW)
                fill++;
            slot = (slot + 1) % WINDOW;
        endfunction

        function int conducting_phase(logic [HALL_BITS-1:0] hall, logic rev);
            int ph;
            ph = PH_U;
            if (!rev)
            begin
                case (hall)
                    3'd1, 3'd3: ph = PH_W;
                    3'd2, 3'd6: ph = PH_V;
                    default:    ph = PH_U;
                endcase
            end
            else
            begin
                case (hall)
                    3'd1, 3'd5: ph = PH_V;
                    3'd4, 3'd6: ph = PH_W;
                    default:    ph = PH_U;
                endcase
            end
            return ph;
        endfunction

        // Advance the filters by one accepted set and queue the currents it owes
        function void note_sample_set(sample_set_t s);
            current_set_t           exp;
            int                     ph;
            logic [SAMPLE_BITS-1:0] raw;
            exp = '0;
            if (svpwm == 0)
            begin
                if (s.hall != HALL_ALL_LOW && s.hall != HALL_ALL_HIGH)
                begin
                    ph = conducting_phase(s.hall, s.rev);
                    raw = (ph == PH_U) ? s.u : (ph == PH_V) ? s.v : s.w;
                    filter_into(0, 0, remove_bias(raw));
                    advance_slot();
                    if (s.run && mean[0] > limit)
                        mean[0] = limit;
                end
                exp[0] = CURRENT_BITS'(mean[0]);
            end
            else
            begin
                filter_into(0, 1, remove_bias(s.u));
                filter_into(1, 2, remove_bias(s.v));
                filter_into(2, 3, remove_bias(s.w));
                advance_slot();
                exp[1] = CURRENT_BITS'(mean[1]);
                exp[2] = CURRENT_BITS'(mean[2]);
                exp[3] = CURRENT_BITS'(mean[3]);
            end
            expected_currents.push_back(exp);
        endfunction

        function void flag(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_currents(logic [OUT_W-1:0] tdata);
            current_set_t got;
            current_set_t exp;
            string        label;
            int           f;
            got = tdata[4*CURRENT_BITS-1:0];
            if (expected_currents.size() == 0)
            begin
                flag($sformatf("result %h with no sample set pending", tdata));
                return;
            end
            exp = expected_currents.pop_front();
            for (f = 0; f < 4; f++)
            begin
                if (got[f] !== exp[f])
                begin
                    case (f)
                        0:       label = "phase_current";
                        1:       label = "current_u";
                        2:       label = "current_v";
                        default: label = "current_w";
                    endcase
                    flag($sformatf("%s mismatch: expected %0d, got %0d",
                                   label, $signed(exp[f]), $signed(got[f])));
                end
            end
        endfunction

        function int pending();
            return expected_currents.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_axis_tvalid;
    logic                      s_axis_tready;
    logic [IN_W-1:0]           s_axis_tdata;  // adc_u, adc_v, adc_w, zero fill
    logic [IN_TUSER_BITS-1:0]  s_axis_tuser;  // hall_code, reverse_dir, run_flag
    logic                      m_axis_tvalid;
    logic                      m_axis_tready;
    logic [OUT_W-1:0]          m_axis_tdata;  // phase_current, current_u, current_v,
                                              // current_w, zero fill

    window_current_board board;

    int send_idle_pct;
    int recv_idle_pct;
    int stall_reqs = 0;
    int stall_taken = 0;
    int stall_left = 0;
    int cycle_count = 0;
    int cur_bias;

    // Shape of the synthetic motor signal
    int                   level [3];
    int                   hall_pos;
    bit                   spin_rev;
    bit                   running;
    logic [HALL_BITS-1:0] hall_cycle [6] = '{3'd1, 3'd3, 3'd2, 3'd6, 3'd4, 3'd5};

    bldc_phase_current_window_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Sample every transfer at the rising edge
    always @(posedge clk)
    begin
        sample_set_t s;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
            begin
                s.u    = s_axis_tdata[SAMPLE_BITS-1:0];
                s.v    = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
                s.w    = s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
                s.hall = s_axis_tuser[HALL_BITS-1:0];
                s.rev  = s_axis_tuser[HALL_BITS];
                s.run  = s_axis_tuser[HALL_BITS+1];
                board.note_sample_set(s);
            end
            if (m_axis_tvalid && m_axis_tready)
                board.check_currents(m_axis_tdata);
        end
    end

    // Drive result-side backpressure; a requested long hold-off overrides it
    always @(negedge clk)
    begin
        if (stall_taken != stall_reqs)
        begin
            stall_left  = LONG_STALL;
            stall_taken = stall_reqs;
        end
        if (!rst_n)
            m_axis_tready = 1'b0;
        else if (stall_left > 0)
        begin
            m_axis_tready = 1'b0;
            stall_left--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] clip_sample(int v);
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Level plus shunt noise, with spikes and fully random codes mixed in
    function automatic logic [SAMPLE_BITS-1:0] noisy_sample(int lvl);
        int r;
        int jitter;
        int spike;
        r      = $urandom_range(99);
        jitter = $urandom_range(120);
        spike  = 300 + $urandom_range(1500);
        if (r < 20)
            return SAMPLE_BITS'($urandom);
        if (r < 28)
            return clip_sample($urandom_range(1) ? lvl + spike : lvl - spike);
        return clip_sample(lvl + jitter - 60);
    endfunction

    // Commutating motor: hall codes follow the rotation, with rare glitches
    function automatic sample_set_t motor_sample_set();
        sample_set_t s;
        int          k;
        int          drift;
        int          r;
        for (k = 0; k < 3; k++)
        begin
            drift    = $urandom_range(80);
            level[k] = clip_sample(level[k] + drift - 40);
        end
        s.u = noisy_sample(level[0]);
        s.v = noisy_sample(level[1]);
        s.w = noisy_sample(level[2]);
        r = $urandom_range(99);
        if (r < 3)
            spin_rev = !spin_rev;
        if (r >= 95)
            running = !running;
        hall_pos = spin_rev ? (hall_pos + 5) % 6 : (hall_pos + 1) % 6;
        s.hall = hall_cycle[hall_pos];
        s.rev  = spin_rev;
        s.run  = running;
        r = $urandom_range(99);
        if (r < 4)
            s.hall = $urandom_range(1) ? HALL_ALL_HIGH : HALL_ALL_LOW;
        else if (r < 8)
        begin
            s.hall = HALL_BITS'($urandom);
            s.rev  = 1'($urandom);
        end
        return s;
    endfunction

    function automatic sample_set_t set_of(int u, int v, int w, int hall, int rev, int run);
        sample_set_t s;
        s.u    = SAMPLE_BITS'(u);
        s.v    = SAMPLE_BITS'(v);
        s.w    = SAMPLE_BITS'(w);
        s.hall = HALL_BITS'(hall);
        s.rev  = 1'(rev);
        s.run  = 1'(run);
        return s;
    endfunction

    task automatic push_set(input sample_set_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata  = {{(IN_W - 3 * SAMPLE_BITS){1'b0}}, s.w, s.v, s.u};
        s_axis_tuser  = {s.run, s.rev, s.hall};
        s_axis_tvalid = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input int mode, input int bias, input int thr, input int lim);
        write_reg(CFG_SVPWM_MODE, CFG_DATA_BITS'(mode));
        write_reg(CFG_CURRENT_BIAS, CFG_DATA_BITS'(bias));
        write_reg(CFG_OUTLIER_THRESHOLD, CFG_DATA_BITS'(thr));
        write_reg(CFG_CURRENT_LIMIT, CFG_DATA_BITS'(lim));
        cur_bias = bias;
    endtask

    // Hold the input until every owed result has come out
    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic seed_levels(input int center);
        int k;
        int off;
        for (k = 0; k < 3; k++)
        begin
            off      = $urandom_range(1600);
            level[k] = clip_sample(center + off - 400);
        end
    endtask

    initial
    begin
        int seg;
        int n;
        int hv;
        int rv;
        board         = new();
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SVPWM_MODE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        send_idle_pct = 17;
        recv_idle_pct = 59;
        cur_bias      = 0;
        hall_pos      = 0;
        spin_rev      = 1'b0;
        running       = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Invalid hall codes straight after reset hold the cleared output
        push_set(set_of(0, 0, 0, HALL_ALL_LOW, 1'b0, 1'b1));
        push_set(set_of(4095, 4095, 4095, HALL_ALL_HIGH, 1'b1, 1'b0));

        // Fill all three windows first so no full window ever drops an unwritten entry
        wait_drained();
        load_settings(1, 2048, 50, 2000);
        push_set(set_of(4095, 0, 2048, 1, 1'b0, 1'b1));
        push_set(set_of(0, 4095, 2049, 0, 1'b1, 1'b0));
        push_set(set_of(2047, 2047, 0, 7, 1'b0, 1'b1));
        push_set(set_of(2048, 2048, 2048, 3, 1'b1, 1'b1));
        push_set(set_of(100, 4000, 3000, 5, 1'b0, 1'b0));
        push_set(set_of(2000, 2100, 2048, 6, 1'b1, 1'b1));
        push_set(set_of(2048, 2048, 2048, 2, 1'b0, 1'b0));
        push_set(set_of(2048, 2049, 2047, 4, 1'b1, 1'b1));
        // Window full: outliers on all three phases against their own means
        push_set(set_of(2060, 4095, 0, 1, 1'b0, 1'b1));
        push_set(set_of(2048, 2048, 2048, 2, 1'b1, 1'b0));

        // Six-step: every valid hall code in both directions, run clamp, held output
        wait_drained();
        load_settings(0, 2048, 4095, 100);
        for (rv = 0; rv < 2; rv++)
            for (hv = 1; hv <= 6; hv++)
                push_set(set_of(2348 + hv, 2648, 2948, hv, rv, hv % 2));
        push_set(set_of(0, 0, 0, HALL_ALL_HIGH, 1'b0, 1'b1));

        // Random motor traffic over a range of settings and idle patterns
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            case (seg / 3)
                0:
                begin
                    send_idle_pct = 17;
                    recv_idle_pct = 59;
                end
                1:
                begin
                    send_idle_pct = 59;
                    recv_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                0:       load_settings(1, 2048, 50, 2000);
                1:       load_settings(0, 0, 0, 0);
                2:       load_settings(1, 4095, 4095, 4095);
                3:       load_settings(0, 4095, 4095, 4095);
                4:       load_settings(1, 0, 0, 0);
                default: load_settings($urandom_range(1), $urandom_range(SAMPLE_MAX),
                                       $urandom_range(1) ? $urandom_range(300)
                                                         : $urandom_range(SAMPLE_MAX),
                                       $urandom_range(SAMPLE_MAX));
            endcase
            if (seg == 1 || seg == 7)
                stall_reqs++;
            seed_levels(cur_bias);
            for (n = 0; n < SEGMENT_SETS; n++)
                push_set(motor_sample_set());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (board.pending() != 0)
            board.flag($sformatf("%0d results never arrived", board.pending()));
        if (board.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
